>>> rtl/core/fpfa_pkg.sv
// shared types and constants of the fixed partition fit allocator
`timescale 1ns / 1ps

package fpfa_pkg;

    // fixed field widths
    localparam int AMOUNT_W   = 16;
    localparam int SLOT_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int PARTS_W    = 5;

    // item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    // fit modes
    localparam logic MODE_FIRST = 1'b0;
    localparam logic MODE_BEST  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PARTS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE     = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_LOADED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_PLACED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_FIT = 2'd2;

    // compare unit verdict on one partition
    typedef struct packed {
        logic fits;    // free and large enough
        logic better;  // strictly smaller than the current best
    } cmp_flags_t;

endpackage

>>> rtl/core/fpfa_table.sv
// partition table: size memory with registered read, taken bits in flops
`timescale 1ns / 1ps

module fpfa_table
    import fpfa_pkg::*;
#(
    parameter int MAX_PARTS = 16,
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 size_we,
    input  logic                 taken_we,
    input  logic                 taken_val,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [SIZE_BITS-1:0] wr_size,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [SIZE_BITS-1:0] rd_size,
    output logic                 rd_taken
);

    logic [SIZE_BITS-1:0] size_mem [MAX_PARTS];
    logic [MAX_PARTS-1:0] taken_reg;
    logic [SIZE_BITS-1:0] rd_size_reg;
    logic                 rd_taken_reg;

    // size memory, no reset
    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[wr_addr] <= wr_size;
        end
        rd_size_reg <= size_mem[rd_addr];
    end

    // taken marks, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg    <= '0;
            rd_taken_reg <= 1'b0;
        end else begin
            if (taken_we) begin
                taken_reg[wr_addr] <= taken_val;
            end
            rd_taken_reg <= taken_reg[rd_addr];
        end
    end

    assign rd_size  = rd_size_reg;
    assign rd_taken = rd_taken_reg;

endmodule

>>> rtl/core/fpfa_cmp.sv
// shared compare and subtract unit for the partition scan
`timescale 1ns / 1ps

module fpfa_cmp
    import fpfa_pkg::*;
#(
    parameter int SIZE_BITS = 16
) (
    input  logic [SIZE_BITS-1:0] size,
    input  logic                 taken,
    input  logic [AMOUNT_W-1:0]  amount,
    input  logic [SIZE_BITS-1:0] best_size,
    output cmp_flags_t           flags,
    output logic [AMOUNT_W-1:0]  leftover
);

    localparam int EXT_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

    logic [EXT_W:0] diff;

    // top bit of diff is the borrow: size below the request
    assign diff         = {1'b0, EXT_W'(size)} - {1'b0, EXT_W'(amount)};
    assign flags.fits   = !taken && !diff[EXT_W];
    assign flags.better = size < best_size;
    assign leftover     = diff[AMOUNT_W-1:0];

endmodule

>>> rtl/core/fixed_partition_fit_allocator.sv
// top level of the fixed partition first fit / best fit allocator
//
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     s_func, s_slot_index, s_amount
//  m_        out        m_valid / m_ready     m_status, m_chosen_slot, m_leftover
//  cfg_      in         cfg_wr_en (no wait)   cfg_index, cfg_wdata
//
// a load transaction is accepted, then written to the result register from the finish state
// an allocate transaction scans n partitions in best fit (n = partitions in use,
// capped at the table size; nothing is scanned when n is zero), reading one
// partition per cycle from the size memory; first fit stops early, once a fit
// is found, and never scans past n
// reset (aresetn, synchronous) marks every partition free, clears the
// configuration registers and the control state; sizes are kept in memory
// a result waiting on m_ready does not block the next accept; only the final
// result commit waits for the output register to be free
`timescale 1ns / 1ps

module fixed_partition_fit_allocator
    import fpfa_pkg::*;
#(
    parameter int MAX_PARTS = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input transactions
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  logic [SLOT_W-1:0]     s_slot_index,
    input  logic [AMOUNT_W-1:0]   s_amount,
    // result transactions
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [SLOT_W-1:0]     m_chosen_slot,
    output logic [AMOUNT_W-1:0]   m_leftover,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // configuration registers
    logic [PARTS_W-1:0] parts_reg, parts_next;
    logic               mode_reg, mode_next;

    // sequencer state
    state_t               state_reg, state_next;
    logic                 func_reg, func_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [AMOUNT_W-1:0]  amount_reg, amount_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]     ev_idx_reg, ev_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] best_reg, best_next;
    logic [AMOUNT_W-1:0]  left_reg, left_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [SLOT_W-1:0]    m_chosen_reg, m_chosen_next;
    logic [AMOUNT_W-1:0]  m_left_reg, m_left_next;

    // table and compare unit hookup
    logic                 size_we;
    logic                 taken_we;
    logic                 taken_val;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_size;
    logic [SIZE_BITS-1:0] rd_size;
    logic                 rd_taken;
    cmp_flags_t           flags;
    logic [AMOUNT_W-1:0]  cmp_left;

    logic out_free;
    logic scan_stop;
    logic issue;

    fpfa_table #(
        .MAX_PARTS (MAX_PARTS),
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .size_we   (size_we),
        .taken_we  (taken_we),
        .taken_val (taken_val),
        .wr_addr   (wr_addr),
        .wr_size   (wr_size),
        .rd_addr   (rd_idx_reg[IDX_W-1:0]),
        .rd_size   (rd_size),
        .rd_taken  (rd_taken)
    );

    fpfa_cmp #(
        .SIZE_BITS (SIZE_BITS)
    ) u_cmp (
        .size      (rd_size),
        .taken     (rd_taken),
        .amount    (amount_reg),
        .best_size (best_reg),
        .flags     (flags),
        .leftover  (cmp_left)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_chosen_slot = m_chosen_reg;
    assign m_leftover    = m_left_reg;

    // output register can take a new result this cycle
    assign out_free  = !m_valid_reg || m_ready;
    // first fit is done once a partition is found
    assign scan_stop = found_reg && (mode_reg == MODE_FIRST);
    // read one more partition this cycle
    assign issue     = (state_reg == ST_SCAN) && (rd_idx_reg < n_reg) && !scan_stop;

    always_comb begin
        parts_next    = parts_reg;
        mode_next     = mode_reg;
        state_next    = state_reg;
        func_next     = func_reg;
        slot_next     = slot_reg;
        amount_next   = amount_reg;
        n_next        = n_reg;
        rd_idx_next   = rd_idx_reg;
        ev_valid_next = ev_valid_reg;
        ev_idx_next   = ev_idx_reg;
        found_next    = found_reg;
        pick_next     = pick_reg;
        best_next     = best_reg;
        left_next     = left_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_chosen_next = m_chosen_reg;
        m_left_next   = m_left_reg;
        size_we       = 1'b0;
        taken_we      = 1'b0;
        taken_val     = 1'b0;
        wr_addr       = IDX_W'(s_slot_index);
        wr_size       = SIZE_BITS'(s_amount);

        // configuration writes, to be issued only while idle; the block does not enforce it
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PARTS_IN_USE: parts_next = cfg_wdata[PARTS_W-1:0];
                CFG_FIT_MODE:     mode_next  = cfg_wdata[0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next     = s_func;
                    slot_next     = s_slot_index;
                    amount_next   = s_amount;
                    rd_idx_next   = '0;
                    ev_valid_next = 1'b0;
                    found_next    = 1'b0;
                    // partitions beyond the table are not scanned
                    if (32'(parts_reg) > MAX_PARTS) begin
                        n_next = CNT_W'(MAX_PARTS);
                    end else begin
                        n_next = CNT_W'(parts_reg);
                    end
                    if (s_func == FUNC_LOAD) begin
                        // load frees the partition; out-of-table index writes nothing
                        if (32'(s_slot_index) < MAX_PARTS) begin
                            size_we   = 1'b1;
                            taken_we  = 1'b1;
                            taken_val = 1'b0;
                        end
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // evaluate the partition read last cycle
                if (ev_valid_reg && flags.fits &&
                    (!found_reg || ((mode_reg == MODE_BEST) && flags.better))) begin
                    found_next = 1'b1;
                    pick_next  = ev_idx_reg;
                    best_next  = rd_size;
                    left_next  = cmp_left;
                end
                ev_valid_next = issue;
                ev_idx_next   = rd_idx_reg[IDX_W-1:0];
                if (issue) begin
                    rd_idx_next = CNT_W'(rd_idx_reg + 1'b1);
                end
                if (!ev_valid_reg && !issue) begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (func_reg == FUNC_LOAD) begin
                        m_status_next = STAT_LOADED;
                        m_chosen_next = slot_reg;
                        m_left_next   = '0;
                    end else if (found_reg) begin
                        m_status_next = STAT_PLACED;
                        m_chosen_next = SLOT_W'(pick_reg);
                        m_left_next   = left_reg;
                        // claim the chosen partition
                        taken_we      = 1'b1;
                        taken_val     = 1'b1;
                        wr_addr       = pick_reg;
                    end else begin
                        m_status_next = STAT_NO_FIT;
                        m_chosen_next = '0;
                        m_left_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // state, control and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            parts_reg    <= '0;
            mode_reg     <= MODE_FIRST;
            ev_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            parts_reg    <= parts_next;
            mode_reg     <= mode_next;
            ev_valid_reg <= ev_valid_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
        end
        func_reg     <= func_next;
        slot_reg     <= slot_next;
        amount_reg   <= amount_next;
        n_reg        <= n_next;
        rd_idx_reg   <= rd_idx_next;
        ev_idx_reg   <= ev_idx_next;
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        left_reg     <= left_next;
        m_status_reg <= m_status_next;
        m_chosen_reg <= m_chosen_next;
        m_left_reg   <= m_left_next;
    end

    // a pending evaluation only exists during the scan
    a_ev_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_valid_reg |-> (state_reg == ST_SCAN))
        else $error("partition evaluation pending outside the scan");

    // the scan pointer never runs past the partitions in use
    a_rd_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (rd_idx_reg <= n_reg))
        else $error("scan pointer beyond partitions in use");

    // a chosen partition lies inside the scanned range
    a_pick_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (found_reg && (state_reg != ST_IDLE)) |-> (CNT_W'(pick_reg) < n_reg))
        else $error("chosen partition outside the scanned range");

    // a new result only appears after a finishing cycle
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result produced outside the finish step");

    // a no-fit result carries no partition and no waste
    a_no_fit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == STAT_NO_FIT)) |->
            ((m_chosen_reg == '0) && (m_left_reg == '0)))
        else $error("no-fit result with nonzero fields");

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for the fixed partition first fit / best fit allocator
`timescale 1ns / 1ps

module tb_top;
    import fpfa_pkg::*;

    localparam int NUM_PARTS    = 16;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 125;
    localparam int DRAIN_CYCLES = 24;      // longer than the slowest scan
    localparam int HOLD_AT      = 300;     // result count at which the sink holds off
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 400000;

    // one expected result transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [AMOUNT_W-1:0] leftover;
    } alloc_result_t;

    // partition table mirror plus the queue of results still owed by the block
    class alloc_scoreboard;
        logic [AMOUNT_W-1:0] part_size [NUM_PARTS];
        bit                  part_taken [NUM_PARTS];
        logic [PARTS_W-1:0]  parts_in_use;
        logic                fit_mode;
        alloc_result_t       owed [$];
        int mismatches;
        int checked;
        int loads;
        int placed;
        int no_fit;
        int settings;

        function new();
            foreach (part_taken[i]) begin
                part_taken[i] = 1'b0;
                part_size[i]  = '0;
            end
            parts_in_use = '0;
            fit_mode     = MODE_FIRST;
            mismatches   = 0;
            checked      = 0;
            loads        = 0;
            placed       = 0;
            no_fit       = 0;
            settings     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_PARTS_IN_USE) begin
                parts_in_use = val;
            end else if (idx == CFG_FIT_MODE) begin
                fit_mode = val[0];
            end
            settings++;
        endfunction

        // work out the result of one accepted transaction and update the table
        function void note_item(logic func, logic [SLOT_W-1:0] idx, logic [AMOUNT_W-1:0] amt);
            alloc_result_t r;
            int  lim;
            int  pick;
            bit  found;
            if (func == FUNC_LOAD) begin
                part_size[idx]  = amt;
                part_taken[idx] = 1'b0;
                r.status   = STAT_LOADED;
                r.slot     = idx;
                r.leftover = '0;
                loads++;
            end else begin
                // a count above the table size means the whole table
                lim   = (parts_in_use > NUM_PARTS) ? NUM_PARTS : int'(parts_in_use);
                found = 1'b0;
                pick  = 0;
                for (int i = 0; i < lim; i++) begin
                    if (!part_taken[i] && part_size[i] >= amt) begin
                        if (!found) begin
                            found = 1'b1;
                            pick  = i;
                            if (fit_mode == MODE_FIRST) break;
                        end else if (part_size[i] < part_size[pick]) begin
                            // strictly smaller only, so ties stay on the lower index
                            pick = i;
                        end
                    end
                end
                if (found) begin
                    part_taken[pick] = 1'b1;
                    r.status   = STAT_PLACED;
                    r.slot     = pick[SLOT_W-1:0];
                    r.leftover = part_size[pick] - amt;
                    placed++;
                end else begin
                    r.status   = STAT_NO_FIT;
                    r.slot     = '0;
                    r.leftover = '0;
                    no_fit++;
                end
            end
            owed.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                                   logic [AMOUNT_W-1:0] leftover);
            alloc_result_t e;
            checked++;
            if (owed.size() == 0) begin
                $error("result transaction with nothing expected: status %0d slot %0d leftover %0d",
                       status, slot, leftover);
                mismatches++;
                return;
            end
            e = owed.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                mismatches++;
            end
            if (slot !== e.slot) begin
                $error("chosen_slot: expected %0d, got %0d", e.slot, slot);
                mismatches++;
            end
            if (leftover !== e.leftover) begin
                $error("leftover: expected %0d, got %0d", e.leftover, leftover);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_func;
    logic [SLOT_W-1:0]     s_slot_index;
    logic [AMOUNT_W-1:0]   s_amount;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_status;
    logic [SLOT_W-1:0]     m_chosen_slot;
    logic [AMOUNT_W-1:0]   m_leftover;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    alloc_scoreboard sb = new();
    int  cycle_count = 0;
    int  sent = 0;
    bit  src_eager = 1'b0;
    bit  sink_eager = 1'b0;

    fixed_partition_fit_allocator #(
        .MAX_PARTS(NUM_PARTS),
        .SIZE_BITS(AMOUNT_W)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_slot_index  (s_slot_index),
        .s_amount      (s_amount),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_chosen_slot (m_chosen_slot),
        .m_leftover    (m_leftover),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog on total run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // offer one input transaction after a random gap; predict it once accepted
    task automatic send_item(input logic func, input logic [SLOT_W-1:0] idx,
                             input logic [AMOUNT_W-1:0] amt);
        int gap;
        // switch between idling and back-to-back stretches now and then
        if (sent % 40 == 0) src_eager = ($urandom_range(0, 3) == 0);
        gap = src_eager ? 0 : $urandom_range(0, 19);
        // valid only drops when a gap follows, so it is never lowered and raised in one step
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= func;
        s_slot_index <= idx;
        s_amount     <= amt;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(func, idx, amt);
        sent++;
    endtask

    // close the input side and let every owed result come back
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one register write, only ever issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] parts, input logic mode);
        write_reg(CFG_PARTS_IN_USE, parts);
        write_reg(CFG_FIT_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
    endtask

    // random transaction; narrow keeps sizes tiny so ties and exact fits are common
    task automatic random_item(input bit narrow);
        int                  pick;
        int                  off;
        int                  k;
        logic [AMOUNT_W-1:0] base;
        logic [AMOUNT_W-1:0] amt;
        logic [SLOT_W-1:0]   idx;
        pick = $urandom_range(0, 9);
        idx  = SLOT_W'($urandom_range(0, NUM_PARTS - 1));
        if (pick < 4) begin
            // a load frees a partition and keeps the table busy
            amt = narrow ? AMOUNT_W'($urandom_range(0, 15)) : AMOUNT_W'($urandom_range(0, 65535));
            send_item(FUNC_LOAD, idx, amt);
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    amt = narrow ? AMOUNT_W'($urandom_range(0, 15))
                                 : AMOUNT_W'($urandom_range(0, 65535));
                end
                3: begin
                    amt = $urandom_range(0, 1) ? '1 : '0;
                end
                default: begin
                    // aim at an existing partition: exact fit, a bit under, or one over
                    k    = $urandom_range(0, NUM_PARTS - 1);
                    base = sb.part_size[k];
                    off  = $urandom_range(0, 4);
                    if (off == 4) amt = base + 1'b1;
                    else          amt = (base >= off) ? base - AMOUNT_W'(off) : '0;
                end
            endcase
            send_item(FUNC_ALLOC, idx, amt);
        end
    endtask

    // result sink: random stalls plus one long hold-off that backs the block up
    initial begin : result_sink
        int stall;
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (sb.checked % 40 == 0) sink_eager = ($urandom_range(0, 3) == 0);
            if (sb.checked == HOLD_AT && !held) begin
                held = 1'b1;
                stall = HOLD_CYCLES;
            end else begin
                stall = sink_eager ? 0 : $urandom_range(0, 19);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_status, m_chosen_slot, m_leftover);
        end
    end

    // main sequence: reset, directed checks, then random phases under several settings
    initial begin : stimulus
        logic [AMOUNT_W-1:0] init_size [NUM_PARTS];
        logic [CFG_DATA_W-1:0] parts_plan [NUM_PHASES];
        logic mode_plan [NUM_PHASES];

        init_size  = '{16'h0000, 16'hFFFF, 16'd40, 16'd40, 16'd7, 16'd100, 16'h8000, 16'd40,
                       16'd3, 16'h7FFF, 16'd12, 16'd40, 16'd1, 16'd500, 16'hAAAA, 16'h5555};
        parts_plan = '{5'd16, 5'd31, 5'd1, 5'd8, 5'd17, 5'd16, 5'd12, 5'd16};
        mode_plan  = '{MODE_FIRST, MODE_BEST, MODE_BEST, MODE_FIRST,
                       MODE_BEST, MODE_FIRST, MODE_BEST, MODE_FIRST};

        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_func       <= FUNC_LOAD;
        s_slot_index <= '0;
        s_amount     <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_PARTS_IN_USE;
        cfg_wdata    <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no partitions in use: nothing is scanned, so the request cannot fit
        set_config(5'd0, MODE_FIRST);
        send_item(FUNC_ALLOC, 4'd9, 16'd0);

        // fill the whole table before anything is scanned
        for (int i = 0; i < NUM_PARTS; i++) send_item(FUNC_LOAD, i[SLOT_W-1:0], init_size[i]);
        drain();

        // first fit: zero request takes partition 0, largest request fits once only
        set_config(5'd16, MODE_FIRST);
        send_item(FUNC_ALLOC, 4'd0, 16'h0000);
        send_item(FUNC_ALLOC, 4'd15, 16'hFFFF);
        send_item(FUNC_ALLOC, 4'd5, 16'hFFFF);
        drain();

        // best fit: equal sizes resolve to the lowest index, then smallest fitting size
        set_config(5'd16, MODE_BEST);
        send_item(FUNC_ALLOC, 4'd3, 16'd40);
        send_item(FUNC_ALLOC, 4'd12, 16'd40);
        send_item(FUNC_ALLOC, 4'd6, 16'd5);
        // reloading a taken partition frees it again
        send_item(FUNC_LOAD, 4'd1, 16'hFFFF);
        send_item(FUNC_ALLOC, 4'd10, 16'h8001);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_config(parts_plan[p], mode_plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) random_item(p % 2 == 1);
            drain();
        end

        $display("covered %0d transactions (%0d loads, %0d placed, %0d no fit)",
                 sent, sb.loads, sb.placed, sb.no_fit);
        $display("over %0d register writes incl. zero, one, full and oversized partition counts",
                 sb.settings);
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
